>>> design/aqi_pkg.sv
// aqi_pkg: item types, breakpoint tables, datapath command/status structs and the
// band function for the air quality index calculator.
// No dependencies.
package aqi_pkg;

	localparam int PM_ROWS  = 7;
	localparam int CO2_ROWS = 9;

	localparam int IDX_W  = 9;   // index width
	localparam int QUOT_W = 9;   // divider quotient bits, one per step
	localparam int NUM_W  = 19;  // interpolation numerator
	localparam int DEN_W  = 12;  // interpolation denominator
	localparam int OFF_W  = 13;  // signed offset into a row
	localparam int AR_W   = 7;   // index span of a row
	localparam int BASE_W = 18;  // den * lower index
	localparam int CNT_W  = $clog2(QUOT_W);

	localparam logic [IDX_W-1:0] PM_ABOVE  = 9'd500;
	localparam logic [IDX_W-1:0] CO2_ABOVE = 9'd400;

	localparam logic [2:0] LEVEL_GOOD      = 3'd0;
	localparam logic [2:0] LEVEL_MODERATE  = 3'd1;
	localparam logic [2:0] LEVEL_SENSITIVE = 3'd2;
	localparam logic [2:0] LEVEL_UNHEALTHY = 3'd3;
	localparam logic [2:0] LEVEL_VERY_BAD  = 3'd4;
	localparam logic [2:0] LEVEL_HAZARDOUS = 3'd5;

	typedef struct packed {
		logic [13:0] c_lo;
		logic [13:0] c_hi;
		logic [8:0]  a_lo;
		logic [8:0]  a_hi;
	} row_t;

	localparam row_t PM_TAB [PM_ROWS] = '{
		'{14'd0,   14'd12,  9'd0,   9'd50},
		'{14'd13,  14'd35,  9'd51,  9'd100},
		'{14'd36,  14'd55,  9'd101, 9'd150},
		'{14'd56,  14'd150, 9'd151, 9'd200},
		'{14'd151, 14'd250, 9'd201, 9'd300},
		'{14'd251, 14'd350, 9'd301, 9'd400},
		'{14'd351, 14'd500, 9'd401, 9'd500}
	};

	localparam row_t CO2_TAB [CO2_ROWS] = '{
		'{14'd0,    14'd400,   9'd0,   9'd0},
		'{14'd401,  14'd1000,  9'd0,   9'd30},
		'{14'd1001, 14'd1500,  9'd31,  9'd50},
		'{14'd1501, 14'd2000,  9'd51,  9'd80},
		'{14'd2001, 14'd3000,  9'd81,  9'd100},
		'{14'd3001, 14'd4000,  9'd101, 9'd150},
		'{14'd4001, 14'd5000,  9'd151, 9'd200},
		'{14'd5001, 14'd6000,  9'd201, 9'd300},
		'{14'd6001, 14'd10000, 9'd301, 9'd400}
	};

	typedef struct packed {
		logic        req_type;
		logic [15:0] co2_ppm;
		logic [15:0] pm25_ugm3;
		logic [15:0] pm10_ugm3;
	} req_item_t;

	typedef struct packed {
		logic [8:0] overall_aqi;
		logic [2:0] overall_level;
		logic [8:0] pm_index;
		logic [8:0] co2_index;
	} rsp_item_t;

	typedef enum logic [1:0] {
		SEL_CO2,
		SEL_PM25,
		SEL_PM10
	} sel_t;

	typedef struct packed {
		logic load;
		logic find;
		sel_t sel;
		logic mul;
		logic step;
		logic save_a;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
	} dp_sts_t;

	function automatic logic [2:0] band(input logic [IDX_W-1:0] a);
		logic [2:0] lvl;
		if (a <= 9'd50)       lvl = LEVEL_GOOD;
		else if (a <= 9'd100) lvl = LEVEL_MODERATE;
		else if (a <= 9'd150) lvl = LEVEL_SENSITIVE;
		else if (a <= 9'd200) lvl = LEVEL_UNHEALTHY;
		else if (a <= 9'd300) lvl = LEVEL_VERY_BAD;
		else                  lvl = LEVEL_HAZARDOUS;
		return lvl;
	endfunction

endpackage

>>> design/aqi_ctrl.sv
// aqi_ctrl: sequencer for the index calculator; drives the datapath commands.
// Depends on aqi_pkg.
module aqi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  aqi_pkg::dp_sts_t  sts,
	output aqi_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_MUL,
		ST_DIV,
		ST_SAVE,
		ST_COMMIT
	} state_t;

	state_t                     state_q;
	logic                       pass_q;
	logic [aqi_pkg::CNT_W-1:0]  cnt_q;
	logic                       valid_q;
	logic                       slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = valid_q;
	assign slot_free = !valid_q || rsp_ready;

	always_comb begin
		cmd = '0;
		cmd.sel = aqi_pkg::SEL_CO2;
		case (state_q)
			ST_IDLE:   cmd.load = req_valid;
			ST_FIND: begin
				cmd.find = 1'b1;
				if (!sts.kind)
					cmd.sel = aqi_pkg::SEL_CO2;
				else if (pass_q)
					cmd.sel = aqi_pkg::SEL_PM10;
				else
					cmd.sel = aqi_pkg::SEL_PM25;
			end
			ST_MUL:    cmd.mul = 1'b1;
			ST_DIV:    cmd.step = 1'b1;
			ST_SAVE:   cmd.save_a = 1'b1;
			ST_COMMIT: cmd.commit = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.commit || (valid_q && !rsp_ready);
			case (state_q)
				ST_IDLE: begin
					pass_q <= 1'b0;
					if (req_valid)
						state_q <= ST_FIND;
				end
				ST_FIND:   state_q <= ST_MUL;
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == aqi_pkg::CNT_W'(aqi_pkg::QUOT_W - 1)) begin
						if (sts.kind && !pass_q)
							state_q <= ST_SAVE;
						else
							state_q <= ST_COMMIT;
					end
				end
				ST_SAVE: begin
					pass_q  <= 1'b1;
					state_q <= ST_FIND;
				end
				ST_COMMIT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/aqi_dp.sv
// aqi_dp: row lookup, interpolation multiply, bit-serial divider, stored indices
// and result register of the index calculator.
// Depends on aqi_pkg.
module aqi_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  aqi_pkg::dp_cmd_t   cmd,
	output aqi_pkg::dp_sts_t   sts,
	input  aqi_pkg::req_item_t req,
	output aqi_pkg::rsp_item_t rsp
);

	aqi_pkg::req_item_t item_q;

	// row lookup
	logic [15:0]                  x;
	logic [16:0]                  v;
	logic                         den3;
	logic                         found;
	logic [16:0]                  sel_clo;
	logic [aqi_pkg::DEN_W-1:0]    sel_d;
	logic [aqi_pkg::BASE_W-1:0]   sel_base;
	logic [aqi_pkg::AR_W-1:0]     sel_ar;
	logic [aqi_pkg::IDX_W-1:0]    sel_alo;
	logic signed [17:0]           off_full;

	logic signed [aqi_pkg::OFF_W-1:0]  off_s1;
	logic [aqi_pkg::DEN_W-1:0]         d_s1;
	logic [aqi_pkg::BASE_W-1:0]        base_s1;
	logic [aqi_pkg::AR_W-1:0]          ar_s1;
	logic [aqi_pkg::IDX_W-1:0]         alo_s1;
	logic                              above_s1;

	// divider
	logic signed [20:0]                prod;
	logic signed [20:0]                num;
	logic [aqi_pkg::NUM_W-1:0]         rem_q;
	logic [aqi_pkg::DEN_W+aqi_pkg::QUOT_W-2:0] dsh_q;
	logic [aqi_pkg::QUOT_W-1:0]        quot_q;
	logic                              fits;

	logic [9:0]                        sum;
	logic [aqi_pkg::IDX_W-1:0]         res;
	logic [aqi_pkg::IDX_W-1:0]         pm_a_q;
	logic [aqi_pkg::IDX_W-1:0]         pm_b_max;
	logic [aqi_pkg::IDX_W-1:0]         last_pm_q;
	logic [aqi_pkg::IDX_W-1:0]         last_co2_q;
	logic [aqi_pkg::IDX_W-1:0]         next_pm;
	logic [aqi_pkg::IDX_W-1:0]         next_co2;
	logic [aqi_pkg::IDX_W-1:0]         overall;
	aqi_pkg::rsp_item_t                rsp_q;

	assign sts.kind = item_q.req_type;
	assign rsp      = rsp_q;

	always_comb begin
		case (cmd.sel)
			aqi_pkg::SEL_CO2:  x = item_q.co2_ppm;
			aqi_pkg::SEL_PM25: x = item_q.pm25_ugm3;
			aqi_pkg::SEL_PM10: x = item_q.pm10_ugm3;
			default:           x = item_q.co2_ppm;
		endcase
		den3 = (cmd.sel == aqi_pkg::SEL_PM10);
		v    = den3 ? {x, 1'b0} : {1'b0, x};

		found    = 1'b0;
		sel_clo  = '0;
		sel_d    = aqi_pkg::DEN_W'(1);
		sel_base = '0;
		sel_ar   = '0;
		sel_alo  = '0;
		// scan downwards so the lowest matching row wins
		if (cmd.sel == aqi_pkg::SEL_CO2) begin
			for (int i = aqi_pkg::CO2_ROWS - 1; i >= 0; i--) begin
				if (v <= 17'(aqi_pkg::CO2_TAB[i].c_hi)) begin
					found    = 1'b1;
					sel_clo  = 17'(aqi_pkg::CO2_TAB[i].c_lo);
					sel_d    = aqi_pkg::DEN_W'(aqi_pkg::CO2_TAB[i].c_hi
					           - aqi_pkg::CO2_TAB[i].c_lo);
					sel_base = '0;
					sel_ar   = aqi_pkg::AR_W'(aqi_pkg::CO2_TAB[i].a_hi
					           - aqi_pkg::CO2_TAB[i].a_lo);
					sel_alo  = aqi_pkg::CO2_TAB[i].a_lo;
				end
			end
		end else begin
			for (int i = aqi_pkg::PM_ROWS - 1; i >= 0; i--) begin
				if (v <= (den3 ? 17'(3 * aqi_pkg::PM_TAB[i].c_hi)
				               : 17'(aqi_pkg::PM_TAB[i].c_hi))) begin
					found    = 1'b1;
					sel_clo  = den3 ? 17'(3 * aqi_pkg::PM_TAB[i].c_lo)
					                : 17'(aqi_pkg::PM_TAB[i].c_lo);
					sel_d    = den3 ? aqi_pkg::DEN_W'(3 * (aqi_pkg::PM_TAB[i].c_hi
					                  - aqi_pkg::PM_TAB[i].c_lo))
					                : aqi_pkg::DEN_W'(aqi_pkg::PM_TAB[i].c_hi
					                  - aqi_pkg::PM_TAB[i].c_lo);
					sel_base = den3 ? aqi_pkg::BASE_W'(3 * (aqi_pkg::PM_TAB[i].c_hi
					                  - aqi_pkg::PM_TAB[i].c_lo) * aqi_pkg::PM_TAB[i].a_lo)
					                : aqi_pkg::BASE_W'((aqi_pkg::PM_TAB[i].c_hi
					                  - aqi_pkg::PM_TAB[i].c_lo) * aqi_pkg::PM_TAB[i].a_lo);
					sel_ar   = aqi_pkg::AR_W'(aqi_pkg::PM_TAB[i].a_hi
					           - aqi_pkg::PM_TAB[i].a_lo);
					sel_alo  = '0;
				end
			end
		end
		off_full = $signed({1'b0, v}) - $signed({1'b0, sel_clo});
	end

	always_comb begin
		prod = 21'(off_s1 * $signed({1'b0, ar_s1}));
		num  = $signed({3'b000, base_s1}) + prod;
		fits = ({1'b0, rem_q} >= dsh_q);
		sum  = {1'b0, alo_s1} + {1'b0, quot_q};
		if (above_s1)
			res = item_q.req_type ? aqi_pkg::PM_ABOVE : aqi_pkg::CO2_ABOVE;
		else
			res = sum[aqi_pkg::IDX_W-1:0];
		pm_b_max = (pm_a_q > res) ? pm_a_q : res;
		next_pm  = item_q.req_type ? pm_b_max : last_pm_q;
		next_co2 = item_q.req_type ? last_co2_q : res;
		overall  = (next_pm > next_co2) ? next_pm : next_co2;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= req;
		if (cmd.find) begin
			off_s1   <= off_full[aqi_pkg::OFF_W-1:0];
			d_s1     <= sel_d;
			base_s1  <= sel_base;
			ar_s1    <= sel_ar;
			alo_s1   <= sel_alo;
			above_s1 <= !found;
		end
		if (cmd.mul) begin
			rem_q  <= num[20] ? '0 : num[aqi_pkg::NUM_W-1:0];
			dsh_q  <= {d_s1, {(aqi_pkg::QUOT_W-1){1'b0}}};
			quot_q <= '0;
		end else if (cmd.step) begin
			if (fits)
				rem_q <= aqi_pkg::NUM_W'({1'b0, rem_q} - dsh_q);
			quot_q <= {quot_q[aqi_pkg::QUOT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
		if (cmd.save_a)
			pm_a_q <= res;
		if (cmd.commit) begin
			rsp_q.overall_aqi   <= overall;
			rsp_q.overall_level <= aqi_pkg::band(overall);
			rsp_q.pm_index      <= next_pm;
			rsp_q.co2_index     <= next_co2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pm_q  <= '0;
			last_co2_q <= '0;
		end else if (cmd.commit) begin
			last_pm_q  <= next_pm;
			last_co2_q <= next_co2;
		end
	end

endmodule

>>> design/air_quality_index_calculator.sv
// Air quality index calculator: one item in, one result item out. Each sub-index
// takes a table lookup, a multiply and the shared restoring divider, a
// particulate item adds a step to hold the PM2.5 index, and a commit writes the
// result register. The block takes one item at a time; a finished result waits
// in the output register while the next item is accepted, and the next result
// is written only once that register is free. Stored indices clear to zero on
// reset.
// Depends on aqi_pkg, aqi_ctrl and aqi_dp.
module air_quality_index_calculator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  aqi_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output aqi_pkg::rsp_item_t rsp
);

	aqi_pkg::dp_cmd_t cmd;
	aqi_pkg::dp_sts_t sts;

	aqi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aqi_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while previous one still in work");

	a_overall_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.overall_aqi == ((rsp.pm_index > rsp.co2_index) ?
		               rsp.pm_index : rsp.co2_index)))
		else $error("overall index is not the larger stored index");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pm_index <= aqi_pkg::PM_ABOVE) &&
		              (rsp.co2_index <= aqi_pkg::CO2_ABOVE))
		else $error("index out of range");

	a_level_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.overall_level == aqi_pkg::band(rsp.overall_aqi)))
		else $error("level does not match overall index");

endmodule
